// ===== src/quadratic_root_solver_top_assert.svh =====
// Assertion macros used by the checker file of the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define QRS_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("quadratic root solver assertion failed");

// Property whose consequent must hold in the cycle after the antecedent.
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("quadratic root solver assertion failed");

`endif

// ===== src/qrs_pkg.sv =====
// Package with constants, codes and stage types of the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int RAD_W     = 66;
   localparam int ROOT_W    = 33;
   localparam int REM_W     = ROOT_W + 3;
   localparam int SQ_STEPS  = ROOT_W;
   localparam int QUO_W     = 33;
   localparam int DVS_W     = 34;
   localparam int DVD_W     = 35 + FRAC_BITS;
   localparam int TOP_W     = DVD_W - QUO_W;
   localparam int DIV_STEPS = QUO_W;

   typedef enum logic [1:0] {
      ST_NONE  = 2'd0,
      ST_OK    = 2'd1,
      ST_DEGEN = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic        an;
      logic        cn;
      logic        qn;
      logic        dzero;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] mc;
   } sqrt_side_type;

   typedef struct packed {
      logic                 valid;
      sqrt_side_type        side;
      logic [RAD_W-1:0]     rad;
      logic [REM_W-1:0]     rem;
      logic [ROOT_W-1:0]    root;
   } sqrt_stage_type;

   typedef struct packed {
      logic [DVS_W-1:0] rem;
      logic [QUO_W-1:0] dvd;
      logic [QUO_W-1:0] quo;
      logic [DVS_W-1:0] dvs;
   } div_lane_type;

   typedef struct packed {
      status_type status;
      logic       an;
      logic       cn;
      logic       qn;
      logic       dzero;
      logic       ovf0;
      logic       ovf1;
   } div_side_type;

   typedef struct packed {
      logic         valid;
      div_side_type side;
      div_lane_type lane0;
      div_lane_type lane1;
   } div_stage_type;

endpackage

// ===== src/quadratic_root_solver_top.sv =====
// Pipeline: a request accepted at one edge passes 71 registers (3 front stages,
// 33 square root cells, 1 setup stage, 33 divider cells, output), and the first
// of them loads at the accepting edge.
// Throughput: one request per cycle; the whole pipeline holds only while the
// output register is full and not taken.
// Reset: synchronous, active high; it clears every stage valid bit and the output valid bit.
`timescale 1ns / 1ps
module quadratic_root_solver_top
   import qrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // coef_a [31:0], coef_b [63:32], coef_c [95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // first_root [31:0], second_root [63:32]
   output logic [2:0]  rsp_tuser    // status [1:0], saturated [2]
);

   logic adv;

   // Front stage A: magnitudes and signs.
   logic        a_valid_ff;
   logic [31:0] a_ma_ff, a_mb_ff, a_mc_ff;
   logic        a_an_ff, a_bn_ff, a_cn_ff;
   // Front stage B: products.
   logic        b_valid_ff;
   logic [63:0] b_sq_ff, b_p_ff;
   logic [31:0] b_ma_ff, b_mb_ff, b_mc_ff;
   logic        b_an_ff, b_cn_ff, b_qn_ff;
   // Stage C: discriminant, loaded into the square root chain.
   sqrt_stage_type c_ff, c_in;
   sqrt_stage_type sq_stage [0:SQ_STEPS];
   // Stage E: divider setup.
   div_stage_type  e_ff, e_in;
   div_stage_type  dv_stage [0:DIV_STEPS];

   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_user_ff, rsp_user_in;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= a_valid_ff;
      end
      if (adv) begin
         a_an_ff <= req_tdata[31];
         a_bn_ff <= req_tdata[63];
         a_cn_ff <= req_tdata[95];
         a_ma_ff <= req_tdata[31] ? (32'd0 - req_tdata[31:0])  : req_tdata[31:0];
         a_mb_ff <= req_tdata[63] ? (32'd0 - req_tdata[63:32]) : req_tdata[63:32];
         a_mc_ff <= req_tdata[95] ? (32'd0 - req_tdata[95:64]) : req_tdata[95:64];
         b_sq_ff <= 64'(a_mb_ff) * 64'(a_mb_ff);
         b_p_ff  <= 64'(a_ma_ff) * 64'(a_mc_ff);
         b_ma_ff <= a_ma_ff;
         b_mb_ff <= a_mb_ff;
         b_mc_ff <= a_mc_ff;
         b_an_ff <= a_an_ff;
         b_cn_ff <= a_cn_ff;
         b_qn_ff <= (a_mb_ff != 32'd0) && !a_bn_ff;
      end
   end

   // Discriminant on magnitudes; 4ac adds when the signs of a and c differ.
   always_comb begin
      logic [RAD_W-1:0] sq66;
      logic [RAD_W-1:0] p66;
      logic             same;
      sq66 = RAD_W'(b_sq_ff);
      p66  = {b_p_ff, 2'b00};
      same = (b_p_ff != 64'd0) && (b_an_ff == b_cn_ff);
      c_in            = '0;
      c_in.valid      = b_valid_ff;
      c_in.side.an    = b_an_ff;
      c_in.side.cn    = b_cn_ff;
      c_in.side.qn    = b_qn_ff;
      c_in.side.ma    = b_ma_ff;
      c_in.side.mb    = b_mb_ff;
      c_in.side.mc    = b_mc_ff;
      if (b_ma_ff == 32'd0) begin
         c_in.side.status = ST_DEGEN;
      end else if (same && (p66 > sq66)) begin
         c_in.side.status = ST_NONE;
      end else begin
         c_in.side.status = ST_OK;
         c_in.rad         = same ? (sq66 - p66) : (sq66 + p66);
      end
      c_in.side.dzero = (c_in.rad == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.valid <= 1'b0;
      end else if (adv) begin
         c_ff <= c_in;
      end
   end

   assign sq_stage[0] = c_ff;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      qrs_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (adv),
         .cell_in  (sq_stage[k]),
         .cell_out (sq_stage[k+1])
      );
   end

   // With a zero discriminant the root is zero, so q/a yields the double root too.
   always_comb begin
      sqrt_stage_type   s;
      logic [DVS_W-1:0] q2;
      logic [DVS_W-1:0] dvs0;
      logic [DVD_W-1:0] dvd0;
      logic [DVD_W-1:0] dvd1;
      logic [TOP_W-1:0] top0;
      logic [TOP_W-1:0] top1;
      s    = sq_stage[SQ_STEPS];
      q2   = DVS_W'(s.side.mb) + DVS_W'(s.root);
      dvs0 = DVS_W'({s.side.ma, 1'b0});
      dvd0 = DVD_W'(q2) << FRAC_BITS;
      dvd1 = DVD_W'(s.side.mc) << (FRAC_BITS + 1);
      top0 = dvd0[DVD_W-1:QUO_W];
      top1 = dvd1[DVD_W-1:QUO_W];
      e_in.valid       = s.valid;
      e_in.side.status = s.side.status;
      e_in.side.an     = s.side.an;
      e_in.side.cn     = s.side.cn;
      e_in.side.qn     = s.side.qn;
      e_in.side.dzero  = s.side.dzero;
      e_in.side.ovf0   = (DVS_W'(top0) >= dvs0);
      e_in.side.ovf1   = (DVS_W'(top1) >= q2);
      e_in.lane0.rem   = DVS_W'(top0);
      e_in.lane0.dvd   = dvd0[QUO_W-1:0];
      e_in.lane0.quo   = '0;
      e_in.lane0.dvs   = dvs0;
      e_in.lane1.rem   = DVS_W'(top1);
      e_in.lane1.dvd   = dvd1[QUO_W-1:0];
      e_in.lane1.quo   = '0;
      e_in.lane1.dvs   = q2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff.valid <= 1'b0;
      end else if (adv) begin
         e_ff <= e_in;
      end
   end

   assign dv_stage[0] = e_ff;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      qrs_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (adv),
         .cell_in  (dv_stage[k]),
         .cell_out (dv_stage[k+1])
      );
   end

   // Applies the sign and clips to the 32-bit range; bit 32 is the clip flag.
   function automatic logic [32:0] clip_root(input logic [QUO_W-1:0] mag,
                                             input logic ovf, input logic neg);
      logic [32:0] res;
      if (neg) begin
         if (ovf || (mag > QUO_W'(33'h080000000))) begin
            res = {1'b1, 32'h80000000};
         end else begin
            res = {1'b0, 32'd0 - mag[31:0]};
         end
      end else begin
         if (ovf || (mag > QUO_W'(33'h07FFFFFFF))) begin
            res = {1'b1, 32'h7FFFFFFF};
         end else begin
            res = {1'b0, mag[31:0]};
         end
      end
      return res;
   endfunction

   always_comb begin
      div_stage_type d;
      logic [32:0]   r0;
      logic [32:0]   r1;
      d  = dv_stage[DIV_STEPS];
      r0 = clip_root(d.lane0.quo, d.side.ovf0, d.side.qn != d.side.an);
      r1 = clip_root(d.lane1.quo, d.side.ovf1, d.side.qn != d.side.cn);
      if (d.side.dzero) begin
         r1 = r0;
      end
      if (d.side.status == ST_OK) begin
         rsp_data_in = {r1[31:0], r0[31:0]};
         rsp_user_in = {r0[32] | r1[32], ST_OK};
      end else begin
         rsp_data_in = '0;
         rsp_user_in = {1'b0, d.side.status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_stage[DIV_STEPS].valid;
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== src/qrs_sqrt_cell.sv =====
// One restoring square root cell: settles one root bit from two radicand bits.
`timescale 1ns / 1ps
module qrs_sqrt_cell
   import qrs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  sqrt_stage_type cell_in,
   output sqrt_stage_type cell_out
);

   sqrt_stage_type   cell_ff;
   sqrt_stage_type   cell_in_next;
   logic [REM_W-1:0] rem2;
   logic [REM_W-1:0] trial;
   logic             ge;

   always_comb begin
      rem2  = {cell_in.rem[REM_W-3:0], cell_in.rad[RAD_W-1 -: 2]};
      trial = {1'b0, cell_in.root, 2'b01};
      ge    = (rem2 >= trial);
      cell_in_next      = cell_in;
      cell_in_next.rem  = ge ? (rem2 - trial) : rem2;
      cell_in_next.root = {cell_in.root[ROOT_W-2:0], ge};
      cell_in_next.rad  = {cell_in.rad[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ===== src/qrs_div_cell.sv =====
// One restoring division cell: settles one quotient bit in each of two lanes.
`timescale 1ns / 1ps
module qrs_div_cell
   import qrs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  div_stage_type cell_in,
   output div_stage_type cell_out
);

   div_stage_type cell_ff;
   div_stage_type cell_in_next;

   function automatic div_lane_type div_step(input div_lane_type ln);
      logic [DVS_W:0] rem2;
      logic [DVS_W:0] dvs2;
      logic           ge;
      div_lane_type   res;
      rem2 = {ln.rem, ln.dvd[QUO_W-1]};
      dvs2 = {1'b0, ln.dvs};
      ge   = (rem2 >= dvs2);
      res      = ln;
      res.rem  = ge ? DVS_W'(rem2 - dvs2) : DVS_W'(rem2);
      res.dvd  = {ln.dvd[QUO_W-2:0], 1'b0};
      res.quo  = {ln.quo[QUO_W-2:0], ge};
      return res;
   endfunction

   always_comb begin
      cell_in_next       = cell_in;
      cell_in_next.lane0 = div_step(cell_in.lane0);
      cell_in_next.lane1 = div_step(cell_in.lane1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ===== src/qrs_checker.sv =====
// Port checker for the quadratic root solver and its bind to the top level.
`timescale 1ns / 1ps
`include "quadratic_root_solver_top_assert.svh"
module qrs_checker
   import qrs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   logic ok_status;
   logic no_roots;
   logic clip0;
   logic clip1;
   logic data_zero;

   assign ok_status = (rsp_tuser[1:0] == ST_OK);
   assign no_roots  = (rsp_tuser[1:0] == ST_NONE) || (rsp_tuser[1:0] == ST_DEGEN);
   assign data_zero = (rsp_tdata == 64'd0);
   // A clipped root always sits at one end of the 32-bit range.
   assign clip0 = (rsp_tdata[31:0] == 32'h80000000) || (rsp_tdata[31:0] == 32'h7FFFFFFF);
   assign clip1 = (rsp_tdata[63:32] == 32'h80000000) || (rsp_tdata[63:32] == 32'h7FFFFFFF);

   `QRS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `QRS_ASSERT_ALWAYS(a_status_code, !rsp_tvalid || ok_status || no_roots)
   `QRS_ASSERT_ALWAYS(a_no_roots_zero, !(rsp_tvalid && no_roots) || (data_zero && !rsp_tuser[2]))
   `QRS_ASSERT_ALWAYS(a_sat_value, !(rsp_tvalid && rsp_tuser[2]) || clip0 || clip1)

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (.*);
